// File: design/cpl_pkg.sv
// Shared constants, types and the restoring-division step for the closest-points block.
// Used by design/cpl_div.sv and design/closest_points_two_lines_3d_top.sv; no dependencies.
`default_nettype none
package cpl_pkg;

    localparam int CRD_W = 16;
    localparam int P2_W  = 17;
    localparam int W_W   = 18;
    localparam int PR_W  = 32;
    localparam int PW_W  = 34;
    localparam int SQ_W  = 32;
    localparam int B_W   = 33;
    localparam int DE_W  = 35;
    localparam int DET_W = 64;
    localparam int NUM_W = 69;
    localparam int MAG_W = 85;
    localparam int FRAC_W = 16;
    localparam int QUO_W = 32;
    localparam int DEN_W = 64;
    localparam int OUT_W = 32;
    localparam int THR_W = 32;
    localparam int PRD_W = 48;
    localparam int SUM_W = 41;

    localparam logic [THR_W-1:0] THR_RESET = 32'd42950;
    localparam logic signed [OUT_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } cpl_lane_t;

    typedef struct packed {
        logic par;
        logic deg;
        logic s_neg;
        logic s_ovf;
        logic s_kill;
        logic t_neg;
        logic t_ovf;
        logic t_kill;
    } cpl_flags_t;

    typedef struct packed {
        logic [2:0][CRD_W-1:0] u;
        logic [2:0][CRD_W-1:0] v;
        logic [2:0][P2_W-1:0]  p2;
        logic [2:0][CRD_W-1:0] q1;
    } cpl_geom_t;

    typedef struct packed {
        cpl_geom_t  geom;
        cpl_flags_t flags;
    } cpl_side_t;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] first;
        logic [2:0][OUT_W-1:0] second;
        logic par;
        logic deg;
        logic sat;
    } cpl_res_t;

    function automatic cpl_lane_t cpl_div_step(input cpl_lane_t x);
        cpl_lane_t        y;
        logic [DEN_W:0]   r2;
        logic [DEN_W:0]   diff;
        y    = x;
        r2   = {x.rem, x.low[QUO_W-1]};
        diff = r2 - {1'b0, x.den};
        y.low = {x.low[QUO_W-2:0], 1'b0};
        if (r2 >= {1'b0, x.den})
        begin
            y.rem = diff[DEN_W-1:0];
            y.quo = {x.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = r2[DEN_W-1:0];
            y.quo = {x.quo[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// File: design/closest_points_two_lines_3d_top.sv
// Closest points between two 3D lines, Q8.8 in, Q16.16 out, fully pipelined.
// Depends on cpl_pkg and cpl_div.
//
// One line pair enters per clock while in_stall is low. The pipeline holds the
// 32-stage divider (one quotient bit per stage) plus seven stages for elementwise
// products, dot products, determinant, numerators, operand setup, point
// products and the output register. A skid register behind the output lets the
// pipeline keep taking pairs while a result waits; in_stall rises only once that
// skid register is full. The threshold write port is always ready and should be
// written while no transaction is in flight.
`default_nettype none
module closest_points_two_lines_3d_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [cpl_pkg::CRD_W-1:0] a_point_x,
    input  logic signed [cpl_pkg::CRD_W-1:0] a_point_y,
    input  logic signed [cpl_pkg::CRD_W-1:0] a_point_z,
    input  logic signed [cpl_pkg::CRD_W-1:0] a_dir_x,
    input  logic signed [cpl_pkg::CRD_W-1:0] a_dir_y,
    input  logic signed [cpl_pkg::CRD_W-1:0] a_dir_z,
    input  logic signed [cpl_pkg::CRD_W-1:0] b_point_x,
    input  logic signed [cpl_pkg::CRD_W-1:0] b_point_y,
    input  logic signed [cpl_pkg::CRD_W-1:0] b_point_z,
    input  logic signed [cpl_pkg::CRD_W-1:0] b_dir_x,
    input  logic signed [cpl_pkg::CRD_W-1:0] b_dir_y,
    input  logic signed [cpl_pkg::CRD_W-1:0] b_dir_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [cpl_pkg::OUT_W-1:0] first_x,
    output logic signed [cpl_pkg::OUT_W-1:0] first_y,
    output logic signed [cpl_pkg::OUT_W-1:0] first_z,
    output logic signed [cpl_pkg::OUT_W-1:0] second_x,
    output logic signed [cpl_pkg::OUT_W-1:0] second_y,
    output logic signed [cpl_pkg::OUT_W-1:0] second_z,
    output logic                             parallel,
    output logic                             degenerate,
    output logic                             saturated,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cpl_pkg::THR_W-1:0]        cfg_data
);
    import cpl_pkg::*;

    function automatic logic [OUT_W:0] quo_fix(
        input logic neg, input logic ovf, input logic kill, input logic [QUO_W-1:0] q);
        logic [OUT_W:0] r;
        if (kill)
            r = '0;
        else if (neg && (ovf || q > {1'b1, {(QUO_W-1){1'b0}}}))
            r = {1'b1, Q_MIN};
        else if (!neg && (ovf || q[QUO_W-1]))
            r = {1'b1, Q_MAX};
        else if (neg)
            r = {1'b0, -q};
        else
            r = {1'b0, q};
        return r;
    endfunction

    function automatic logic [OUT_W:0] coord_fix(input logic [SUM_W-1:0] s);
        logic [OUT_W:0] r;
        if (s[SUM_W-1:OUT_W-1] == '0 || s[SUM_W-1:OUT_W-1] == '1)
            r = {1'b0, s[OUT_W-1:0]};
        else if (s[SUM_W-1])
            r = {1'b1, Q_MIN};
        else
            r = {1'b1, Q_MAX};
        return r;
    endfunction

    logic en;
    logic [THR_W-1:0] thr_reg;

    logic signed [CRD_W-1:0] pa [3];
    logic signed [CRD_W-1:0] da [3];
    logic signed [CRD_W-1:0] pb [3];
    logic signed [CRD_W-1:0] db [3];
    logic signed [P2_W-1:0]  p2_c [3];
    logic signed [W_W-1:0]   w_c  [3];
    cpl_geom_t               geom_c;
    logic signed [PR_W-1:0]  uu_c [3];
    logic signed [PR_W-1:0]  uv_c [3];
    logic signed [PR_W-1:0]  vv_c [3];
    logic signed [PW_W-1:0]  uw_c [3];
    logic signed [PW_W-1:0]  vw_c [3];

    logic                    s1_valid_reg;
    cpl_geom_t               s1_geom_reg;
    logic signed [PR_W-1:0]  s1_uu_reg [3];
    logic signed [PR_W-1:0]  s1_uv_reg [3];
    logic signed [PR_W-1:0]  s1_vv_reg [3];
    logic signed [PW_W-1:0]  s1_uw_reg [3];
    logic signed [PW_W-1:0]  s1_vw_reg [3];

    logic                    s2_valid_reg;
    cpl_geom_t               s2_geom_reg;
    logic [SQ_W-1:0]         s2_a_reg;
    logic signed [B_W-1:0]   s2_b_reg;
    logic [SQ_W-1:0]         s2_c_reg;
    logic signed [DE_W-1:0]  s2_d_reg;
    logic signed [DE_W-1:0]  s2_e_reg;
    logic [SQ_W-1:0]         a_c;
    logic signed [B_W-1:0]   b_c;
    logic [SQ_W-1:0]         c_c;
    logic signed [DE_W-1:0]  d_c;
    logic signed [DE_W-1:0]  e_c;

    logic [B_W-1:0]          ub_c;
    logic                    s3_valid_reg;
    cpl_geom_t               s3_geom_reg;
    logic [DET_W-1:0]        s3_ac_reg;
    logic [DET_W-1:0]        s3_bb_reg;
    logic signed [NUM_W-1:0] s3_be_reg;
    logic signed [NUM_W-1:0] s3_cd_reg;
    logic signed [NUM_W-1:0] s3_ae_reg;
    logic signed [NUM_W-1:0] s3_bd_reg;
    logic                    s3_bgc_reg;
    logic [SQ_W-1:0]         s3_b_reg;
    logic [SQ_W-1:0]         s3_c_reg;
    logic signed [DE_W-1:0]  s3_d_reg;
    logic signed [DE_W-1:0]  s3_e_reg;

    logic                    s4_valid_reg;
    cpl_geom_t               s4_geom_reg;
    logic [DET_W-1:0]        s4_det_reg;
    logic signed [NUM_W-1:0] s4_ns_reg;
    logic signed [NUM_W-1:0] s4_nt_reg;
    logic                    s4_bgc_reg;
    logic [SQ_W-1:0]         s4_b_reg;
    logic [SQ_W-1:0]         s4_c_reg;
    logic signed [DE_W-1:0]  s4_d_reg;
    logic signed [DE_W-1:0]  s4_e_reg;

    logic                    par_c;
    logic [NUM_W-1:0]        ns_abs_c;
    logic [NUM_W-1:0]        nt_abs_c;
    logic signed [DE_W-1:0]  pnum_c;
    logic [DE_W-1:0]         pnum_abs_c;
    logic                    t_neg_c;
    logic [MAG_W-1:0]        t_mag_c;
    logic [DEN_W-1:0]        t_den_c;

    logic                    s5_valid_reg;
    cpl_geom_t               s5_geom_reg;
    logic                    s5_par_reg;
    logic                    s5_s_neg_reg;
    logic [MAG_W-1:0]        s5_s_mag_reg;
    logic [DEN_W-1:0]        s5_s_den_reg;
    logic                    s5_t_neg_reg;
    logic [MAG_W-1:0]        s5_t_mag_reg;
    logic [DEN_W-1:0]        s5_t_den_reg;

    logic                    s_zero_c;
    logic                    t_zero_c;
    cpl_side_t               div_side_c;
    cpl_lane_t               div_s_c;
    cpl_lane_t               div_t_c;

    logic                    dv_valid;
    cpl_side_t               dv_side;
    logic [QUO_W-1:0]        dv_quo_s;
    logic [QUO_W-1:0]        dv_quo_t;
    logic [OUT_W:0]          sc_fix_c;
    logic [OUT_W:0]          tc_fix_c;
    logic signed [OUT_W-1:0] sc_c;
    logic signed [OUT_W-1:0] tc_c;
    logic signed [PRD_W-1:0] ps_c [3];
    logic signed [PRD_W-1:0] pt_c [3];

    logic                    s7_valid_reg;
    cpl_geom_t               s7_geom_reg;
    logic                    s7_par_reg;
    logic                    s7_deg_reg;
    logic                    s7_sat_reg;
    logic signed [PRD_W-1:0] s7_ps_reg [3];
    logic signed [PRD_W-1:0] s7_pt_reg [3];

    logic [SUM_W-1:0]        sum_f_c [3];
    logic [SUM_W-1:0]        sum_s_c [3];
    logic [OUT_W:0]          fix_f_c [3];
    logic [OUT_W:0]          fix_s_c [3];
    cpl_res_t                res_c;

    logic                    out_valid_reg;
    logic                    skid_valid_reg;
    cpl_res_t                out_data_reg;
    cpl_res_t                skid_data_reg;

    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // Stage 1: anchor points, offsets and elementwise products
    always_comb
    begin
        pa[0] = a_point_x; pa[1] = a_point_y; pa[2] = a_point_z;
        da[0] = a_dir_x;   da[1] = a_dir_y;   da[2] = a_dir_z;
        pb[0] = b_point_x; pb[1] = b_point_y; pb[2] = b_point_z;
        db[0] = b_dir_x;   db[1] = b_dir_y;   db[2] = b_dir_z;
        for (int k = 0; k < 3; k++)
        begin
            p2_c[k] = {pa[k][CRD_W-1], pa[k]} + {da[k][CRD_W-1], da[k]};
            w_c[k]  = {p2_c[k][P2_W-1], p2_c[k]} - {{2{pb[k][CRD_W-1]}}, pb[k]};
            uu_c[k] = da[k] * da[k];
            uv_c[k] = da[k] * db[k];
            vv_c[k] = db[k] * db[k];
            uw_c[k] = da[k] * w_c[k];
            vw_c[k] = db[k] * w_c[k];
            geom_c.u[k]  = da[k];
            geom_c.v[k]  = db[k];
            geom_c.p2[k] = p2_c[k];
            geom_c.q1[k] = pb[k];
        end
    end

    // Stage 2: dot products
    always_comb
    begin
        a_c = s1_uu_reg[0] + s1_uu_reg[1] + s1_uu_reg[2];
        b_c = B_W'(s1_uv_reg[0]) + B_W'(s1_uv_reg[1]) + B_W'(s1_uv_reg[2]);
        c_c = s1_vv_reg[0] + s1_vv_reg[1] + s1_vv_reg[2];
        d_c = DE_W'(s1_uw_reg[0]) + DE_W'(s1_uw_reg[1]) + DE_W'(s1_uw_reg[2]);
        e_c = DE_W'(s1_vw_reg[0]) + DE_W'(s1_vw_reg[1]) + DE_W'(s1_vw_reg[2]);
    end

    assign ub_c = s2_b_reg[B_W-1] ? B_W'(-s2_b_reg) : B_W'(s2_b_reg);

    // Stage 5: parallel decision and divider operands
    always_comb
    begin
        par_c      = s4_det_reg < {{(DET_W-THR_W){1'b0}}, thr_reg};
        ns_abs_c   = s4_ns_reg[NUM_W-1] ? NUM_W'(-s4_ns_reg) : NUM_W'(s4_ns_reg);
        nt_abs_c   = s4_nt_reg[NUM_W-1] ? NUM_W'(-s4_nt_reg) : NUM_W'(s4_nt_reg);
        pnum_c     = s4_bgc_reg ? s4_d_reg : s4_e_reg;
        pnum_abs_c = pnum_c[DE_W-1] ? DE_W'(-pnum_c) : DE_W'(pnum_c);
        if (par_c)
        begin
            t_neg_c = pnum_c[DE_W-1];
            t_mag_c = {{(MAG_W-DE_W-FRAC_W){1'b0}}, pnum_abs_c, {FRAC_W{1'b0}}};
            t_den_c = {{(DEN_W-SQ_W){1'b0}}, (s4_bgc_reg ? s4_b_reg : s4_c_reg)};
        end
        else
        begin
            t_neg_c = s4_nt_reg[NUM_W-1];
            t_mag_c = {nt_abs_c, {FRAC_W{1'b0}}};
            t_den_c = s4_det_reg;
        end
    end

    // Stage 6: zero and overflow checks, divider lane setup
    always_comb
    begin
        s_zero_c = s5_s_den_reg == '0;
        t_zero_c = s5_t_den_reg == '0;
        div_side_c.geom         = s5_geom_reg;
        div_side_c.flags.par    = s5_par_reg;
        div_side_c.flags.deg    = (!s5_par_reg && s_zero_c) || t_zero_c;
        div_side_c.flags.s_neg  = s5_s_neg_reg;
        div_side_c.flags.s_ovf  = DEN_W'(s5_s_mag_reg[MAG_W-1:QUO_W]) >= s5_s_den_reg;
        div_side_c.flags.s_kill = s5_par_reg || s_zero_c;
        div_side_c.flags.t_neg  = s5_t_neg_reg;
        div_side_c.flags.t_ovf  = DEN_W'(s5_t_mag_reg[MAG_W-1:QUO_W]) >= s5_t_den_reg;
        div_side_c.flags.t_kill = t_zero_c;
        div_s_c.rem = DEN_W'(s5_s_mag_reg[MAG_W-1:QUO_W]);
        div_s_c.low = s5_s_mag_reg[QUO_W-1:0];
        div_s_c.den = s5_s_den_reg;
        div_s_c.quo = '0;
        div_t_c.rem = DEN_W'(s5_t_mag_reg[MAG_W-1:QUO_W]);
        div_t_c.low = s5_t_mag_reg[QUO_W-1:0];
        div_t_c.den = s5_t_den_reg;
        div_t_c.quo = '0;
    end

    cpl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_side   (div_side_c),
        .in_s      (div_s_c),
        .in_t      (div_t_c),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo_s (dv_quo_s),
        .out_quo_t (dv_quo_t)
    );

    // Stage 7: line parameters and offset products
    always_comb
    begin
        sc_fix_c = quo_fix(dv_side.flags.s_neg, dv_side.flags.s_ovf, dv_side.flags.s_kill,
                           dv_quo_s);
        tc_fix_c = quo_fix(dv_side.flags.t_neg, dv_side.flags.t_ovf, dv_side.flags.t_kill,
                           dv_quo_t);
        sc_c = $signed(sc_fix_c[OUT_W-1:0]);
        tc_c = $signed(tc_fix_c[OUT_W-1:0]);
        for (int k = 0; k < 3; k++)
        begin
            ps_c[k] = sc_c * $signed(dv_side.geom.u[k]);
            pt_c[k] = tc_c * $signed(dv_side.geom.v[k]);
        end
    end

    // Output: coordinate sums with clamping
    always_comb
    begin
        res_c.par = s7_par_reg;
        res_c.deg = s7_deg_reg;
        res_c.sat = s7_sat_reg;
        for (int k = 0; k < 3; k++)
        begin
            sum_f_c[k] = {{(SUM_W-P2_W-8){s7_geom_reg.p2[k][P2_W-1]}}, s7_geom_reg.p2[k], 8'b0}
                       + {s7_ps_reg[k][PRD_W-1], s7_ps_reg[k][PRD_W-1:8]};
            sum_s_c[k] = {{(SUM_W-CRD_W-8){s7_geom_reg.q1[k][CRD_W-1]}}, s7_geom_reg.q1[k], 8'b0}
                       + {s7_pt_reg[k][PRD_W-1], s7_pt_reg[k][PRD_W-1:8]};
            fix_f_c[k] = coord_fix(sum_f_c[k]);
            fix_s_c[k] = coord_fix(sum_s_c[k]);
            res_c.first[k]  = fix_f_c[k][OUT_W-1:0];
            res_c.second[k] = fix_s_c[k][OUT_W-1:0];
            res_c.sat = res_c.sat | fix_f_c[k][OUT_W] | fix_s_c[k][OUT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s7_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_geom_reg <= geom_c;
            for (int k = 0; k < 3; k++)
            begin
                s1_uu_reg[k] <= uu_c[k];
                s1_uv_reg[k] <= uv_c[k];
                s1_vv_reg[k] <= vv_c[k];
                s1_uw_reg[k] <= uw_c[k];
                s1_vw_reg[k] <= vw_c[k];
            end

            s2_geom_reg <= s1_geom_reg;
            s2_a_reg    <= a_c;
            s2_b_reg    <= b_c;
            s2_c_reg    <= c_c;
            s2_d_reg    <= d_c;
            s2_e_reg    <= e_c;

            s3_geom_reg <= s2_geom_reg;
            s3_ac_reg   <= s2_a_reg * s2_c_reg;
            s3_bb_reg   <= ub_c[SQ_W-1:0] * ub_c[SQ_W-1:0];
            s3_be_reg   <= s2_b_reg * s2_e_reg;
            s3_cd_reg   <= $signed({1'b0, s2_c_reg}) * s2_d_reg;
            s3_ae_reg   <= $signed({1'b0, s2_a_reg}) * s2_e_reg;
            s3_bd_reg   <= s2_b_reg * s2_d_reg;
            s3_bgc_reg  <= s2_b_reg > $signed({1'b0, s2_c_reg});
            s3_b_reg    <= s2_b_reg[SQ_W-1:0];
            s3_c_reg    <= s2_c_reg;
            s3_d_reg    <= s2_d_reg;
            s3_e_reg    <= s2_e_reg;

            s4_geom_reg <= s3_geom_reg;
            s4_det_reg  <= s3_ac_reg - s3_bb_reg;
            s4_ns_reg   <= s3_be_reg - s3_cd_reg;
            s4_nt_reg   <= s3_ae_reg - s3_bd_reg;
            s4_bgc_reg  <= s3_bgc_reg;
            s4_b_reg    <= s3_b_reg;
            s4_c_reg    <= s3_c_reg;
            s4_d_reg    <= s3_d_reg;
            s4_e_reg    <= s3_e_reg;

            s5_geom_reg  <= s4_geom_reg;
            s5_par_reg   <= par_c;
            s5_s_neg_reg <= s4_ns_reg[NUM_W-1];
            s5_s_mag_reg <= {ns_abs_c, {FRAC_W{1'b0}}};
            s5_s_den_reg <= s4_det_reg;
            s5_t_neg_reg <= t_neg_c;
            s5_t_mag_reg <= t_mag_c;
            s5_t_den_reg <= t_den_c;

            s7_geom_reg <= dv_side.geom;
            s7_par_reg  <= dv_side.flags.par;
            s7_deg_reg  <= dv_side.flags.deg;
            s7_sat_reg  <= sc_fix_c[OUT_W] || tc_fix_c[OUT_W];
            for (int k = 0; k < 3; k++)
            begin
                s7_ps_reg[k] <= ps_c[k];
                s7_pt_reg[k] <= pt_c[k];
            end
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && out_stall)
        begin
            if (s7_valid_reg)
                skid_valid_reg <= 1'b1;
        end
        else
        begin
            out_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
                out_data_reg <= skid_data_reg;
        end
        else if (out_valid_reg && out_stall)
        begin
            skid_data_reg <= res_c;
        end
        else
        begin
            out_data_reg <= res_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign first_x    = $signed(out_data_reg.first[0]);
    assign first_y    = $signed(out_data_reg.first[1]);
    assign first_z    = $signed(out_data_reg.first[2]);
    assign second_x   = $signed(out_data_reg.second[0]);
    assign second_y   = $signed(out_data_reg.second[1]);
    assign second_z   = $signed(out_data_reg.second[2]);
    assign parallel   = out_data_reg.par;
    assign degenerate = out_data_reg.deg;
    assign saturated  = out_data_reg.sat;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && s7_valid_reg))
        else $error("skid filled without a stalled output and a finished transaction");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted transaction did not enter the first stage");

endmodule
`default_nettype wire

// File: design/cpl_div.sv
// Pipelined restoring divider: two quotient lanes, one quotient bit per stage.
// Depends on cpl_pkg; side data and valid bits travel alongside the lanes.
`default_nettype none
module cpl_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  cpl_pkg::cpl_side_t       in_side,
    input  cpl_pkg::cpl_lane_t       in_s,
    input  cpl_pkg::cpl_lane_t       in_t,
    output logic                     out_valid,
    output cpl_pkg::cpl_side_t       out_side,
    output logic [cpl_pkg::QUO_W-1:0] out_quo_s,
    output logic [cpl_pkg::QUO_W-1:0] out_quo_t
);
    import cpl_pkg::*;

    logic [QUO_W-1:0] vld_reg;
    cpl_side_t        side_reg [QUO_W];
    cpl_lane_t        s_reg    [QUO_W];
    cpl_lane_t        t_reg    [QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            s_reg[0]    <= cpl_div_step(in_s);
            t_reg[0]    <= cpl_div_step(in_t);
            for (int i = 1; i < QUO_W; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                s_reg[i]    <= cpl_div_step(s_reg[i-1]);
                t_reg[i]    <= cpl_div_step(t_reg[i-1]);
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign out_quo_s = s_reg[QUO_W-1].quo;
    assign out_quo_t = t_reg[QUO_W-1].quo;

endmodule
`default_nettype wire
